>>> design/wris_pkg.sv
// Shared types and constants of the weighted random index selector.
`timescale 1ns / 1ps

package wris_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = ADDR_W + 1;
  localparam int FRAC_BITS = 16;
  localparam int CUM_W = 48;
  localparam int SUM_W = 40;   // sum of all clamped entries fits here
  localparam int DEN_W = FRAC_BITS + 1;
  localparam int RAW_W = 32;

  localparam logic [CUM_W-1:0] CUM_MAX = {CUM_W{1'b1}};
  localparam logic [CUM_W-1:0] ONE_FX = CUM_W'(1) << FRAC_BITS;
  localparam logic [CUM_W-1:0] NEAR_ONE_LSB = CUM_W'((64'd1 << FRAC_BITS) / 64'd1000000);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_SUM_LAST,
    S_DECIDE,
    S_DIV_Q,
    S_P2_RD,
    S_P2_DAT,
    S_P2_DIV,
    S_P2_ACC,
    S_SEL_LO,
    S_SEL_HI,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_BACK_RD,
    S_BACK_CMP
  } wris_state_t;

  // Request and response of the shared divider
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } wris_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [SUM_W-1:0] quo;
    logic [DEN_W-1:0] rem;
  } wris_div_rsp_t;

endpackage

>>> design/wris_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module wris_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wris_pkg::wris_div_req_t req,
  output wris_pkg::wris_div_rsp_t rsp
);

  localparam int CW = $clog2(wris_pkg::SUM_W);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [wris_pkg::SUM_W-1:0]    quo_r, quo_nxt;
  logic [wris_pkg::DEN_W-1:0]    rem_r, rem_nxt;
  logic [wris_pkg::DEN_W-1:0]    dvs_r, dvs_nxt;
  logic [wris_pkg::DEN_W:0]      shifted;

  // One shift-compare-subtract step
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    shifted  = {rem_r, quo_r[wris_pkg::SUM_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(wris_pkg::SUM_W - 1);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = wris_pkg::DEN_W'(shifted - {1'b0, dvs_r});
        quo_nxt = {quo_r[wris_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[wris_pkg::DEN_W-1:0];
        quo_nxt = {quo_r[wris_pkg::SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

>>> design/weighted_random_index_selector.sv
// Top level: entry table, cumulative table, cook and search sequencer.
// The load marked last starts cooking: a sum pass over the entries, a divide in
// mixture mode, then a pass that builds the cumulative table, in which each
// nonzero probability entry in mixture mode uses the shared divider.
// Select: a binary search over the cumulative memory port, after the weight
// roll for weight tables and followed by a walk back over trailing zero entries.
// Reset (synchronous, rst_n low) empties the table and closes loading.
`timescale 1ns / 1ps

module weighted_random_index_selector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // entry_value[31:0], random_fraction[47:32]
  input  logic [1:0]  in_tuser,   // req_type[0], entry_is_prob[1]
  input  logic        in_tlast,   // entry_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // selected_index[7:0]
  output logic [1:0]  out_tuser   // selected_valid[0], table_is_prob[1]
);

  localparam int AW = wris_pkg::ADDR_W;
  localparam int CW = wris_pkg::CNT_W;
  localparam int SW = wris_pkg::SUM_W;
  localparam int UW = wris_pkg::CUM_W;
  localparam int DW = wris_pkg::DEN_W;
  localparam int FB = wris_pkg::FRAC_BITS;
  localparam int PW = FB + SW;

  // Memories
  logic [wris_pkg::RAW_W:0] raw_mem [wris_pkg::MAX_ENTRIES];
  logic [UW-1:0]            cum_mem [wris_pkg::MAX_ENTRIES];

  wris_pkg::wris_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic          load_open_r, load_open_nxt;
  logic [UW-1:0] total_r, total_nxt;
  logic          prob_r, prob_nxt;
  logic          mix_r, mix_nxt;
  logic          rd_v_r, rd_v_nxt;
  logic [SW-1:0] sw_r, sw_nxt, sp_r, sp_nxt;
  logic [UW-1:0] acc_r, acc_nxt;
  logic [SW-1:0] q_r, q_nxt;
  logic [DW-1:0] r_r, r_nxt, d_r, d_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [UW-1:0] add_r, add_nxt;
  logic [15:0]   rf_r, rf_nxt;
  logic [UW-1:0] roll_r, roll_nxt;
  logic [SW-1:0] plo_r, plo_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, k_r, k_nxt;
  logic          out_v_r, out_v_nxt;
  logic [7:0]    out_idx_r, out_idx_nxt;
  logic          out_ok_r, out_ok_nxt;
  logic          out_prob_r, out_prob_nxt;

  logic                     raw_we;
  logic [AW-1:0]            raw_wa, raw_ra, cum_wa, cum_ra;
  logic [wris_pkg::RAW_W:0] raw_wd, raw_q_r;
  logic                     cum_we;
  logic [UW-1:0]            cum_wd, cum_q_r;

  wris_pkg::wris_div_req_t div_req;
  wris_pkg::wris_div_rsp_t div_rsp;

  logic          in_acc;
  logic [31:0]   raw_v;
  logic          raw_f;
  logic [30:0]   v_clamp;
  logic [CW-1:0] ld_idx, mid_c, k_fin;
  logic [CW:0]   mid_sum;
  logic [UW:0]   acc_sum;
  logic [PW:0]   scl_sum;
  logic [UW-1:0] hi_part;
  logic [UW:0]   roll_sum;
  logic          fail;

  wris_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_tready = (state_r == wris_pkg::S_IDLE) && !out_v_r;
  assign in_acc    = in_tvalid && in_tready;
  assign raw_v     = raw_q_r[31:0];
  assign raw_f     = raw_q_r[32];
  assign v_clamp   = raw_v[31] ? 31'd0 : raw_v[30:0];

  // Sequencer: loads, cooking passes, search and walk-back
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    load_open_nxt = load_open_r;
    total_nxt     = total_r;
    prob_nxt      = prob_r;
    mix_nxt       = mix_r;
    rd_v_nxt      = 1'b0;
    sw_nxt        = sw_r;
    sp_nxt        = sp_r;
    acc_nxt       = acc_r;
    q_nxt         = q_r;
    r_nxt         = r_r;
    d_nxt         = d_r;
    prod_nxt      = prod_r;
    add_nxt       = add_r;
    rf_nxt        = rf_r;
    roll_nxt      = roll_r;
    plo_nxt       = plo_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    k_nxt         = k_r;
    out_v_nxt     = out_v_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_ok_nxt    = out_ok_r;
    out_prob_nxt  = out_prob_r;
    raw_we        = 1'b0;
    raw_wa        = '0;
    raw_wd        = {in_tuser[1], in_tdata[31:0]};
    raw_ra        = i_r[AW-1:0];
    cum_we        = 1'b0;
    cum_wa        = i_r[AW-1:0];
    cum_wd        = '0;
    cum_ra        = '0;
    div_req       = '0;
    ld_idx        = load_open_r ? cnt_r : '0;
    mid_sum       = {1'b0, lo_r} + {1'b0, hi_r};
    mid_c         = mid_sum[CW:1];
    k_fin         = lo_r;
    acc_sum       = {1'b0, acc_r} + {1'b0, add_r};
    scl_sum       = {1'b0, prod_r} + (PW+1)'(div_rsp.quo);
    hi_part       = '0;
    roll_sum      = '0;
    fail          = 1'b0;

    // Pass-one accumulation follows the read in the next cycle
    if (rd_v_r) begin
      if (raw_f) sp_nxt = sp_r + SW'(v_clamp);
      else       sw_nxt = sw_r + SW'(v_clamp);
    end

    case (state_r)
      wris_pkg::S_IDLE: begin
        if (in_acc && !in_tuser[0]) begin
          // Load transfer
          cnt_nxt = ld_idx;
          if (ld_idx < CW'(wris_pkg::MAX_ENTRIES)) begin
            raw_we  = 1'b1;
            raw_wa  = ld_idx[AW-1:0];
            cnt_nxt = ld_idx + CW'(1);
          end
          load_open_nxt = !in_tlast;
          if (in_tlast) begin
            i_nxt     = '0;
            sw_nxt    = '0;
            sp_nxt    = '0;
            state_nxt = wris_pkg::S_SUM;
          end
        end else if (in_acc) begin
          // Select transfer
          rf_nxt = in_tdata[47:32];
          if (load_open_r || cnt_r == '0 || total_r == '0) begin
            out_v_nxt    = 1'b1;
            out_ok_nxt   = 1'b0;
            out_idx_nxt  = '0;
            out_prob_nxt = prob_r;
          end else if (prob_r) begin
            roll_nxt  = UW'(in_tdata[47:32]) << (FB - 16);
            lo_nxt    = '0;
            hi_nxt    = cnt_r;
            state_nxt = wris_pkg::S_SRCH_RD;
          end else begin
            state_nxt = wris_pkg::S_SEL_LO;
          end
        end
      end
      wris_pkg::S_SUM: begin
        rd_v_nxt = 1'b1;
        i_nxt    = i_r + CW'(1);
        if (i_r == cnt_r - CW'(1)) state_nxt = wris_pkg::S_SUM_LAST;
      end
      wris_pkg::S_SUM_LAST: state_nxt = wris_pkg::S_DECIDE;
      wris_pkg::S_DECIDE: begin
        i_nxt   = '0;
        acc_nxt = '0;
        d_nxt   = DW'(wris_pkg::ONE_FX - UW'(sp_r));
        if (sp_r == '0) begin
          prob_nxt  = 1'b0;
          mix_nxt   = 1'b0;
          state_nxt = wris_pkg::S_P2_RD;
        end else if (sw_r == '0 ||
                     UW'(sp_r) + wris_pkg::NEAR_ONE_LSB >= wris_pkg::ONE_FX) begin
          prob_nxt  = 1'b1;
          mix_nxt   = 1'b0;
          state_nxt = wris_pkg::S_P2_RD;
        end else begin
          prob_nxt         = 1'b0;
          mix_nxt          = 1'b1;
          div_req.start    = 1'b1;
          div_req.dividend = sw_r;
          div_req.divisor  = DW'(wris_pkg::ONE_FX - UW'(sp_r));
          state_nxt        = wris_pkg::S_DIV_Q;
        end
      end
      wris_pkg::S_DIV_Q: begin
        if (div_rsp.done) begin
          q_nxt     = div_rsp.quo;
          r_nxt     = div_rsp.rem;
          state_nxt = wris_pkg::S_P2_RD;
        end
      end
      wris_pkg::S_P2_RD: state_nxt = wris_pkg::S_P2_DAT;
      wris_pkg::S_P2_DAT: begin
        add_nxt   = '0;
        state_nxt = wris_pkg::S_P2_ACC;
        if (mix_r) begin
          if (raw_f && v_clamp != '0) begin
            // Scaled probability: v*q + floor(v*r/d)
            prod_nxt         = v_clamp[FB-1:0] * q_r;
            div_req.start    = 1'b1;
            div_req.dividend = v_clamp[FB-1:0] * r_r;
            div_req.divisor  = d_r;
            state_nxt        = wris_pkg::S_P2_DIV;
          end else begin
            add_nxt = UW'(v_clamp);
          end
        end else if (raw_f == prob_r) begin
          add_nxt = UW'(v_clamp);
        end
      end
      wris_pkg::S_P2_DIV: begin
        if (div_rsp.done) begin
          add_nxt   = (scl_sum > (PW+1)'(wris_pkg::CUM_MAX)) ? wris_pkg::CUM_MAX
                                                            : scl_sum[UW-1:0];
          state_nxt = wris_pkg::S_P2_ACC;
        end
      end
      wris_pkg::S_P2_ACC: begin
        acc_nxt = (acc_sum > (UW+1)'(wris_pkg::CUM_MAX)) ? wris_pkg::CUM_MAX
                                                         : acc_sum[UW-1:0];
        cum_we  = 1'b1;
        cum_wd  = acc_nxt;
        i_nxt   = i_r + CW'(1);
        state_nxt = wris_pkg::S_P2_RD;
        if (prob_r && i_r + CW'(1) < cnt_r && acc_nxt >= wris_pkg::ONE_FX) begin
          // Probability table cut off once it reaches one
          cnt_nxt   = i_r + CW'(1);
          total_nxt = acc_nxt;
          state_nxt = wris_pkg::S_IDLE;
        end else if (i_r == cnt_r - CW'(1)) begin
          total_nxt = acc_nxt;
          state_nxt = wris_pkg::S_IDLE;
        end
      end
      wris_pkg::S_SEL_LO: begin
        plo_nxt   = rf_r * total_r[23:0];
        state_nxt = wris_pkg::S_SEL_HI;
      end
      wris_pkg::S_SEL_HI: begin
        // (rf * total) >> 16 from the two partial products
        hi_part   = rf_r * total_r[UW-1:24];
        roll_sum  = {1'b0, hi_part[UW-9:0], 8'd0} + (UW+1)'(plo_r >> 16);
        roll_nxt  = roll_sum[UW-1:0];
        lo_nxt    = '0;
        hi_nxt    = cnt_r - CW'(1);
        state_nxt = wris_pkg::S_SRCH_RD;
      end
      wris_pkg::S_SRCH_RD: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_c;
          cum_ra    = mid_c[AW-1:0];
          state_nxt = wris_pkg::S_SRCH_CMP;
        end else begin
          if (prob_r && lo_r == cnt_r) begin
            if (total_r + wris_pkg::NEAR_ONE_LSB < wris_pkg::ONE_FX) fail = 1'b1;
            k_fin = cnt_r - CW'(1);
          end
          k_nxt = k_fin;
          if (fail) begin
            out_v_nxt    = 1'b1;
            out_ok_nxt   = 1'b0;
            out_idx_nxt  = '0;
            out_prob_nxt = prob_r;
            state_nxt    = wris_pkg::S_IDLE;
          end else if (k_fin == cnt_r - CW'(1)) begin
            state_nxt = wris_pkg::S_BACK_RD;
          end else begin
            out_v_nxt    = 1'b1;
            out_ok_nxt   = 1'b1;
            out_idx_nxt  = k_fin[7:0];
            out_prob_nxt = prob_r;
            state_nxt    = wris_pkg::S_IDLE;
          end
        end
      end
      wris_pkg::S_SRCH_CMP: begin
        if (cum_q_r > roll_r) hi_nxt = mid_r;
        else                  lo_nxt = mid_r + CW'(1);
        state_nxt = wris_pkg::S_SRCH_RD;
      end
      wris_pkg::S_BACK_RD: begin
        // Last entry equals the total; step back past equal predecessors
        cum_ra = AW'(k_r - CW'(1));
        if (k_r == '0) begin
          out_v_nxt    = 1'b1;
          out_ok_nxt   = 1'b1;
          out_idx_nxt  = k_r[7:0];
          out_prob_nxt = prob_r;
          state_nxt    = wris_pkg::S_IDLE;
        end else begin
          state_nxt = wris_pkg::S_BACK_CMP;
        end
      end
      wris_pkg::S_BACK_CMP: begin
        if (cum_q_r == total_r) begin
          k_nxt     = k_r - CW'(1);
          state_nxt = wris_pkg::S_BACK_RD;
        end else begin
          out_v_nxt    = 1'b1;
          out_ok_nxt   = 1'b1;
          out_idx_nxt  = k_r[7:0];
          out_prob_nxt = prob_r;
          state_nxt    = wris_pkg::S_IDLE;
        end
      end
      default: state_nxt = wris_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wris_pkg::S_IDLE;
      cnt_r       <= '0;
      load_open_r <= 1'b0;
      total_r     <= '0;
      prob_r      <= 1'b0;
      mix_r       <= 1'b0;
      rd_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      load_open_r <= load_open_nxt;
      total_r     <= total_nxt;
      prob_r      <= prob_nxt;
      mix_r       <= mix_nxt;
      rd_v_r      <= rd_v_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    sw_r       <= sw_nxt;
    sp_r       <= sp_nxt;
    acc_r      <= acc_nxt;
    q_r        <= q_nxt;
    r_r        <= r_nxt;
    d_r        <= d_nxt;
    prod_r     <= prod_nxt;
    add_r      <= add_nxt;
    rf_r       <= rf_nxt;
    roll_r     <= roll_nxt;
    plo_r      <= plo_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    k_r        <= k_nxt;
    out_idx_r  <= out_idx_nxt;
    out_ok_r   <= out_ok_nxt;
    out_prob_r <= out_prob_nxt;
  end

  // Entry memory
  always_ff @(posedge clk) begin
    if (raw_we) raw_mem[raw_wa] <= raw_wd;
    raw_q_r <= raw_mem[raw_ra];
  end

  // Cumulative memory
  always_ff @(posedge clk) begin
    if (cum_we) cum_mem[cum_wa] <= cum_wd;
    cum_q_r <= cum_mem[cum_ra];
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_idx_r;
  assign out_tuser  = {out_prob_r, out_ok_r};

  // Checks
  a_ready_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_v_r)
    else $error("input ready while a result is pending");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(wris_pkg::MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_fail_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ok_r) |-> (out_idx_r == '0))
    else $error("failed selection with nonzero index");

  a_sel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0]) |=> (state_r != wris_pkg::S_IDLE || out_v_r))
    else $error("select transfer dropped");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the weighted random index selector.
`timescale 1ns / 1ps

module testbench;

  typedef enum bit {REQ_LOAD = 1'b0, REQ_SELECT = 1'b1} req_kind_t;

  typedef struct {
    req_kind_t   kind;
    logic [31:0] value;
    logic        is_prob;
    logic        last;
    logic [15:0] roll;
  } request_t;

  typedef struct {
    logic [7:0] index;
    logic       chosen;
    logic       prob_table;
  } choice_t;

  // Directed row: request plus an optional typed-in expectation
  typedef struct {
    request_t req;
    bit       typed;
    choice_t  want;
  } stim_row_t;

  localparam longint unsigned SAT48 = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned ONE = 64'(wris_pkg::ONE_FX);
  localparam longint unsigned NEAR = 64'(wris_pkg::NEAR_ONE_LSB);
  localparam int N_ITEMS = 1650;
  localparam longint CYCLE_LIMIT = 3_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;

  weighted_random_index_selector dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Predictor state
  logic [31:0]     tbl_raw [wris_pkg::MAX_ENTRIES];
  logic            tbl_isp [wris_pkg::MAX_ENTRIES];
  longint unsigned tbl_cum [wris_pkg::MAX_ENTRIES];
  int              tbl_n;
  longint unsigned tbl_total;
  bit              tbl_pmode;
  bit              tbl_open;

  choice_t   pending_choices[$];
  stim_row_t rows[$];
  int        mismatches;
  longint    cycles;
  bit        calm;

  function automatic longint unsigned clamp_val(logic [31:0] raw);
    return raw[31] ? 64'd0 : 64'(raw);
  endfunction

  function automatic longint unsigned sat48(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > SAT48) ? SAT48 : s;
  endfunction

  // Builds the cumulative table once the last entry has arrived
  function automatic void cook_table();
    longint unsigned sw, sp, acc, v, d, q, r, sc;
    int n;
    sw = 0; sp = 0; acc = 0; n = tbl_n;
    for (int i = 0; i < n; i++) begin
      if (tbl_isp[i]) sp += clamp_val(tbl_raw[i]);
      else sw += clamp_val(tbl_raw[i]);
    end
    if (sp == 0) begin
      tbl_pmode = 0;
      for (int i = 0; i < n; i++) begin
        if (!tbl_isp[i]) acc += clamp_val(tbl_raw[i]);
        tbl_cum[i] = acc;
      end
    end else if (sw == 0 || sp + NEAR >= ONE) begin
      tbl_pmode = 1;
      for (int i = 0; i < n; i++) begin
        if (tbl_isp[i]) acc += clamp_val(tbl_raw[i]);
        tbl_cum[i] = acc;
        if (i + 1 < n && acc >= ONE) begin
          n = i + 1;
          break;
        end
      end
      tbl_n = n;
    end else begin
      d = ONE - sp;
      q = sw / d;
      r = sw % d;
      tbl_pmode = 0;
      for (int i = 0; i < n; i++) begin
        v = clamp_val(tbl_raw[i]);
        if (!tbl_isp[i] || v == 0) sc = tbl_isp[i] ? 64'd0 : v;
        else if (q > SAT48 / v) sc = SAT48;
        else sc = sat48(v * q, (v * r) / d);
        acc = sat48(acc, sc);
        tbl_cum[i] = acc;
      end
    end
    tbl_total = acc;
  endfunction

  // First index below lim whose cumulative value exceeds the roll
  function automatic int first_above(longint unsigned roll, int lim);
    int lo, hi, mid;
    lo = 0; hi = lim;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_cum[mid] > roll) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  // Skip back over trailing entries that add nothing
  function automatic int skip_flat(int idx);
    while (idx > 0 && tbl_cum[idx] == tbl_cum[idx-1]) idx--;
    return idx;
  endfunction

  function automatic choice_t pick_entry(logic [15:0] rf);
    choice_t c;
    int k, n;
    c.index = 0; c.chosen = 0; c.prob_table = tbl_pmode;
    n = tbl_n;
    if (tbl_open || n == 0) return c;
    if (!tbl_pmode) begin
      if (n == 1) begin
        c.chosen = tbl_cum[0] > 0;
        return c;
      end
      if (tbl_total == 0) return c;
      k = first_above((64'(rf) * tbl_total) >> 16, n - 1);
      if (k == n - 1) k = skip_flat(k);
    end else begin
      if (tbl_total == 0) return c;
      k = first_above((64'(rf) << wris_pkg::FRAC_BITS) >> 16, n);
      if (k == n) begin
        if (tbl_cum[n-1] + NEAR < ONE) return c;
        k = n - 1;
      end
      if (k == n - 1) k = skip_flat(k);
    end
    c.index = k[7:0];
    c.chosen = 1;
    return c;
  endfunction

  // Advances the predictor by one accepted transfer
  function automatic bit apply_request(request_t rq, output choice_t c);
    if (rq.kind == REQ_LOAD) begin
      if (!tbl_open) begin
        tbl_n = 0;
        tbl_open = 1;
      end
      if (tbl_n < wris_pkg::MAX_ENTRIES) begin
        tbl_raw[tbl_n] = rq.value;
        tbl_isp[tbl_n] = rq.is_prob;
        tbl_n++;
      end
      if (rq.last) begin
        tbl_open = 0;
        cook_table();
      end
      return 0;
    end
    c = pick_entry(rq.roll);
    return 1;
  endfunction

  // Drives one transfer; typed rows override the predicted choice
  task automatic drive_request(request_t rq, bit typed, choice_t want);
    choice_t c;
    int gap;
    if (!calm && $urandom_range(99) < 22) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {rq.roll, rq.value};
    in_tuser <= {rq.is_prob, rq.kind};
    in_tlast <= rq.last;
    do @(posedge clk); while (!in_tready);
    if (apply_request(rq, c)) pending_choices.push_back(typed ? want : c);
  endtask

  function automatic request_t load_req(logic [31:0] v, logic p, logic l);
    request_t rq;
    rq.kind = REQ_LOAD; rq.value = v; rq.is_prob = p; rq.last = l;
    rq.roll = 16'($urandom);
    return rq;
  endfunction

  function automatic request_t sel_req(logic [15:0] rf);
    request_t rq;
    rq.kind = REQ_SELECT; rq.value = $urandom; rq.is_prob = 1'($urandom_range(1));
    rq.last = 1'($urandom_range(1)); rq.roll = rf;
    return rq;
  endfunction

  function automatic void add_row(request_t rq, bit typed = 0, logic [7:0] idx = 0,
                                  logic ok = 0, logic pm = 0);
    stim_row_t r;
    r.req = rq; r.typed = typed;
    r.want.index = idx; r.want.chosen = ok; r.want.prob_table = pm;
    rows.push_back(r);
  endfunction

  // Random entry value: small weights, probability slices, negatives, raw noise
  function automatic logic [31:0] rand_value(logic p, int n);
    case ($urandom_range(9))
      0: return 32'h8000_0000 | 32'($urandom);
      1: return 32'($urandom);
      2: return 32'd0;
      default: return p ? 32'($urandom_range(0, 2 * 65536 / n))
                        : 32'($urandom_range(0, 200000));
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle budget
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: check each transfer against the oldest expectation
  always @(posedge clk) begin
    choice_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_choices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result idx=%0d user=%b", out_tdata, out_tuser);
      end else begin
        e = pending_choices.pop_front();
        if (out_tdata !== e.index || out_tuser[0] !== e.chosen ||
            out_tuser[1] !== e.prob_table) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx=%0d valid=%b prob=%b, got idx=%0d valid=%b prob=%b",
                     e.index, e.chosen, e.prob_table,
                     out_tdata, out_tuser[0], out_tuser[1]);
        end
      end
    end
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
  end

  initial begin
    int sent, n, k;
    logic p;
    choice_t none;
    none = '{default: 0};
    cycles = 0; mismatches = 0; calm = 0;
    tbl_n = 0; tbl_total = 0; tbl_pmode = 0; tbl_open = 0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0; in_tlast = 1'b0;
    out_tready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    add_row(sel_req(16'h1234), 1, 0, 0, 0);                   // empty after reset
    add_row(load_req(32'd0, 0, 1));
    add_row(sel_req(16'hFFFF), 1, 0, 0, 0);                   // single zero weight
    add_row(load_req(32'd5, 0, 1));
    add_row(sel_req(16'hFFFF), 1, 0, 1, 0);                   // single weight taken
    add_row(load_req(32'h8000_0000, 0, 1));
    add_row(sel_req(16'h0000), 1, 0, 0, 0);                   // negative clamps to zero
    add_row(load_req(32'h0000_8000, 1, 0));
    add_row(load_req(32'h0000_8000, 1, 1));
    add_row(sel_req(16'h0000), 1, 0, 1, 1);                   // sum exactly one
    add_row(sel_req(16'hFFFF), 1, 1, 1, 1);
    add_row(load_req(32'h0000_4000, 1, 1));
    add_row(sel_req(16'h8000), 1, 0, 0, 1);                   // roll past total
    add_row(load_req(32'h0001_0000, 0, 0));
    add_row(load_req(32'h0000_8000, 1, 1));                   // mixture
    add_row(sel_req(16'h0000));
    add_row(sel_req(16'hFFFF));
    add_row(load_req(32'h7FFF_FFFF, 0, 0));
    add_row(sel_req(16'h4000), 1, 0, 0, 0);                   // select while loading
    add_row(load_req(32'd0, 0, 0));
    add_row(load_req(32'hFFFF_FFFF, 1, 1));                   // trailing zero entries
    add_row(sel_req(16'hFFFF));
    add_row(load_req(32'h0001_0000, 1, 0));
    add_row(load_req(32'h0000_1000, 1, 1));                   // cut off after reaching one
    add_row(sel_req(16'hFFFF));
    foreach (rows[i]) drive_request(rows[i].req, rows[i].typed, rows[i].want);
    sent = rows.size();

    // Random tables followed by bursts of selects
    while (sent < N_ITEMS) begin
      calm = (sent > 600 && sent < 800);
      k = $urandom_range(99);
      n = (k < 3) ? $urandom_range(250, 262) : (k < 10) ? $urandom_range(9, 40)
                                                         : $urandom_range(1, 8);
      k = $urandom_range(3);
      for (int i = 0; i < n; i++) begin
        p = (k == 0) ? 1'b0 : (k == 1) ? 1'b1 : 1'($urandom_range(1));
        drive_request(load_req(rand_value(p, n), p, i == n - 1), 0, none);
        sent++;
        if ($urandom_range(99) < 2) begin
          drive_request(sel_req(16'($urandom)), 0, none);
          sent++;
        end
      end
      repeat ($urandom_range(1, 6)) begin
        drive_request(sel_req(16'($urandom)), 0, none);
        sent++;
      end
    end
    in_tvalid <= 1'b0;

    while (pending_choices.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_choices.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
design/wris_pkg.sv
design/wris_div.sv
design/weighted_random_index_selector.sv
tb/testbench.sv
